FILE: design/imu_sfd_pkg.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder package
// Frame bytes, kind codes and the fixed scaling constants of the decoder.
// ----------------------------------------------------------------------------
package imu_sfd_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [7:0] TYPE_MAG   = 8'h54;

    localparam int         HOLD_MAX   = 10;
    localparam logic [3:0] HOLD_FULL  = 4'd10;

    typedef enum logic [1:0] {
        KIND_ACC   = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2,
        KIND_MAG   = 2'd3
    } t_kind;

    // Acceleration is raw*1568/5 = raw*313 + trunc(raw*3/5).
    localparam logic signed [31:0] ACC_BASE_MUL    = 32'sd313;
    localparam logic [34:0]        ACC_RECIP       = 35'd209716;
    localparam int                 ACC_RECIP_SHIFT = 20;
    localparam logic [31:0]        TEMP_RECIP      = 32'd41944;
    localparam int                 TEMP_SHIFT      = 22;
    localparam logic signed [31:0] RATE_MUL        = 32'sd4000;
    localparam logic signed [31:0] ANGLE_MUL       = 32'sd360;

endpackage

FILE: design/imu_serial_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder
// Collects received bytes into an 11-byte frame window, checks the sum and
// emits the four decoded words scaled to signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one received byte per item in tdata[7:0].
// The master stream gives one item per good frame of a known type.
// Its tdata holds value_x [31:0], value_y [63:32], value_z [95:64] and
// temperature [127:96]; its tuser holds frame_kind [1:0] and
// temperature_valid [2].
// Bytes pass an input register, the window stage and the scaling stage
// into the output register. One byte is taken every cycle until a
// receiver stall has filled all stages; the window update and the checksum
// run in the combinational logic between the input register and the
// decode register.
// A bad checksum slides the window by one byte, and a byte at the head
// that is not a header leaves the window.
// While the receiver stalls, bytes keep entering until the three stages
// are full; frames without a result use no slot.
// Reset empties the window and all stages; the window contents are not
// cleared.
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // rx_byte
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // value_x, value_y, value_z, temperature
    output logic [2:0]   o_m_axis_tuser    // frame_kind, temperature_valid
);

    function automatic logic signed [31:0] f_scale_axis(
        input imu_sfd_pkg::t_kind kind,
        input logic signed [15:0] raw
    );
        logic signed [17:0] tri3;
        logic [16:0]        mag;
        logic [34:0]        prod;
        logic [14:0]        q;
        logic signed [31:0] qs;
        logic signed [31:0] res;
        tri3 = 18'(raw) + (18'(raw) <<< 1);
        mag  = tri3[17] ? 17'(-tri3) : tri3[16:0];
        prod = 35'(mag) * imu_sfd_pkg::ACC_RECIP;
        q    = 15'(prod >> imu_sfd_pkg::ACC_RECIP_SHIFT);
        qs   = tri3[17] ? -$signed({17'd0, q}) : $signed({17'd0, q});
        case (kind)
            imu_sfd_pkg::KIND_ACC:   res = 32'(raw) * imu_sfd_pkg::ACC_BASE_MUL + qs;
            imu_sfd_pkg::KIND_RATE:  res = 32'(raw) * imu_sfd_pkg::RATE_MUL;
            imu_sfd_pkg::KIND_ANGLE: res = 32'(raw) * imu_sfd_pkg::ANGLE_MUL;
            imu_sfd_pkg::KIND_MAG:   res = {raw, 16'h0000};
            default:                 res = '0;
        endcase
        return res;
    endfunction

    function automatic logic signed [31:0] f_scale_temp(
        input imu_sfd_pkg::t_kind kind,
        input logic signed [15:0] raw
    );
        logic [15:0]        mag;
        logic [31:0]        prod;
        logic [8:0]         q;
        logic signed [15:0] t16;
        logic signed [31:0] res;
        mag  = raw[15] ? 16'(-raw) : raw;
        prod = 32'(mag) * imu_sfd_pkg::TEMP_RECIP;
        q    = 9'(prod >> imu_sfd_pkg::TEMP_SHIFT);
        t16  = raw[15] ? -$signed({7'd0, q}) : $signed({7'd0, q});
        case (kind)
            imu_sfd_pkg::KIND_ACC: res = {t16, 16'h0000};
            imu_sfd_pkg::KIND_MAG: res = {raw, 16'h0000};
            default:               res = '0;
        endcase
        return res;
    endfunction

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic [7:0]          r_win [imu_sfd_pkg::HOLD_MAX];
    logic [7:0]          n_win [imu_sfd_pkg::HOLD_MAX];
    logic [3:0]          r_cnt;
    logic [3:0]          n_cnt;
    logic                r_mid_valid;
    imu_sfd_pkg::t_kind  r_mid_kind;
    logic signed [15:0]  r_mid_raw [4];
    logic                r_out_valid;
    logic [127:0]        r_out_data;
    logic [2:0]          r_out_user;

    logic [7:0]          bufb [imu_sfd_pkg::HOLD_MAX + 1];
    logic [7:0]          sum;
    logic                emit;
    imu_sfd_pkg::t_kind  dec_kind;
    logic                adv_out;
    logic                adv_mid;
    logic                take_in;

    assign adv_out         = !r_out_valid || i_m_axis_tready;
    assign adv_mid         = !r_mid_valid || adv_out;
    assign o_s_axis_tready = !r_in_valid || adv_mid;
    assign take_in         = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        for (int i = 0; i < imu_sfd_pkg::HOLD_MAX; i++) begin
            bufb[i] = (4'(i) < r_cnt) ? r_win[i] : r_in_byte;
        end
        bufb[imu_sfd_pkg::HOLD_MAX] = r_in_byte;
        sum = '0;
        for (int i = 0; i < imu_sfd_pkg::HOLD_MAX; i++) begin
            sum = sum + bufb[i];
        end
        n_win    = r_win;
        n_cnt    = r_cnt;
        emit     = 1'b0;
        dec_kind = imu_sfd_pkg::KIND_ACC;
        if (bufb[0] != imu_sfd_pkg::HDR_BYTE) begin
            for (int i = 0; i < imu_sfd_pkg::HOLD_MAX; i++) begin
                n_win[i] = bufb[i + 1];
            end
        end else if (r_cnt < imu_sfd_pkg::HOLD_FULL) begin
            n_win[r_cnt] = r_in_byte;
            n_cnt        = r_cnt + 4'd1;
        end else if (sum == bufb[imu_sfd_pkg::HOLD_MAX]) begin
            n_cnt = '0;
            case (bufb[1])
                imu_sfd_pkg::TYPE_ACC: begin
                    emit     = 1'b1;
                    dec_kind = imu_sfd_pkg::KIND_ACC;
                end
                imu_sfd_pkg::TYPE_RATE: begin
                    emit     = 1'b1;
                    dec_kind = imu_sfd_pkg::KIND_RATE;
                end
                imu_sfd_pkg::TYPE_ANGLE: begin
                    emit     = 1'b1;
                    dec_kind = imu_sfd_pkg::KIND_ANGLE;
                end
                imu_sfd_pkg::TYPE_MAG: begin
                    emit     = 1'b1;
                    dec_kind = imu_sfd_pkg::KIND_MAG;
                end
                default: begin
                    emit     = 1'b0;
                    dec_kind = imu_sfd_pkg::KIND_ACC;
                end
            endcase
        end else begin
            for (int i = 0; i < imu_sfd_pkg::HOLD_MAX; i++) begin
                n_win[i] = bufb[i + 1];
            end
            n_cnt = imu_sfd_pkg::HOLD_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_cnt       <= '0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (adv_mid) begin
                r_mid_valid <= r_in_valid && emit;
                if (r_in_valid) begin
                    r_cnt <= n_cnt;
                end
            end
            if (adv_out) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (adv_mid && r_in_valid) begin
            r_win <= n_win;
        end
        if (adv_mid) begin
            r_mid_kind   <= dec_kind;
            r_mid_raw[0] <= $signed({bufb[3], bufb[2]});
            r_mid_raw[1] <= $signed({bufb[5], bufb[4]});
            r_mid_raw[2] <= $signed({bufb[7], bufb[6]});
            r_mid_raw[3] <= $signed({bufb[9], bufb[8]});
        end
        if (adv_out) begin
            r_out_data <= {f_scale_temp(r_mid_kind, r_mid_raw[3]),
                           f_scale_axis(r_mid_kind, r_mid_raw[2]),
                           f_scale_axis(r_mid_kind, r_mid_raw[1]),
                           f_scale_axis(r_mid_kind, r_mid_raw[0])};
            r_out_user <= {(r_mid_kind == imu_sfd_pkg::KIND_ACC ||
                            r_mid_kind == imu_sfd_pkg::KIND_MAG), r_mid_kind};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= imu_sfd_pkg::HOLD_FULL)
        else $error("Held byte count exceeds the window size.");

    a_emit_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv_mid && r_in_valid && emit) |=> (r_cnt == '0 && r_mid_valid))
        else $error("A decoded frame did not empty the window.");

    a_emit_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && emit) |-> (r_cnt == imu_sfd_pkg::HOLD_FULL))
        else $error("A frame was decoded from a window that was not full.");

    a_tvalid_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[2] ==
            (o_m_axis_tuser[1:0] == imu_sfd_pkg::KIND_ACC ||
             o_m_axis_tuser[1:0] == imu_sfd_pkg::KIND_MAG)))
        else $error("Temperature flag does not match the frame kind.");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_mid_valid && r_out_valid))
        else $error("Input stalled while a stage was empty.");
`endif

endmodule

FILE: dv/imu_serial_frame_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder testbench
// Sends received bytes into the decoder, both as clean frames and as broken
// traffic. A byte-level model of the frame window predicts every decoded
// sample, and each output item is compared field by field with the oldest
// prediction. Both stream sides stall at random, except in the closing part.
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder_top_tb;

    localparam int FRAME_LEN      = 11;
    localparam int RANDOM_BYTES   = 1350;
    localparam int TOTAL_BYTES    = 1550;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct {
        imu_sfd_pkg::t_kind kind;
        logic [31:0]        x;
        logic [31:0]        y;
        logic [31:0]        z;
        logic [31:0]        temp;
        logic               temp_valid;
    } t_imu_sample;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [7:0]   i_s_axis_tdata;   // rx_byte
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [127:0] o_m_axis_tdata;   // value_x, value_y, value_z, temperature
    logic [2:0]   o_m_axis_tuser;   // frame_kind, temperature_valid

    t_imu_sample expected_samples[$];
    logic [7:0]  window_bytes [imu_sfd_pkg::HOLD_MAX];
    int          held_bytes;
    int          error_count;
    int          bytes_sent;
    int          quiet_cycles;
    bit          idle_enable;

    imu_serial_frame_decoder_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // The window drops its head byte when it is not a header or the sum is bad; a good frame empties it.
    function automatic void decode_rx_byte(logic [7:0] rx);
        logic [7:0]  frame [FRAME_LEN];
        logic [7:0]  sum;
        longint      raw [4];
        t_imu_sample s;
        int          n;
        n = held_bytes;
        for (int i = 0; i < n; i++) frame[i] = window_bytes[i];
        frame[n] = rx;
        n++;
        if (frame[0] != imu_sfd_pkg::HDR_BYTE || n < FRAME_LEN) begin
            if (frame[0] != imu_sfd_pkg::HDR_BYTE) begin
                for (int i = 0; i < n - 1; i++) frame[i] = frame[i + 1];
                n--;
            end
            for (int i = 0; i < n; i++) window_bytes[i] = frame[i];
            held_bytes = n;
            return;
        end
        sum = 8'd0;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + frame[i];
        if (sum != frame[FRAME_LEN - 1]) begin
            for (int i = 0; i < imu_sfd_pkg::HOLD_MAX; i++) window_bytes[i] = frame[i + 1];
            held_bytes = imu_sfd_pkg::HOLD_MAX;
            return;
        end
        held_bytes = 0;
        for (int k = 0; k < 4; k++) begin
            raw[k] = longint'(shortint'({frame[3 + 2 * k], frame[2 + 2 * k]}));
        end
        case (frame[1])
            imu_sfd_pkg::TYPE_ACC: begin
                s.kind       = imu_sfd_pkg::KIND_ACC;
                s.x          = 32'(raw[0] * 1568 / 5);
                s.y          = 32'(raw[1] * 1568 / 5);
                s.z          = 32'(raw[2] * 1568 / 5);
                s.temp       = 32'((raw[3] / 100) * 65536);
                s.temp_valid = 1'b1;
            end
            imu_sfd_pkg::TYPE_RATE: begin
                s.kind       = imu_sfd_pkg::KIND_RATE;
                s.x          = 32'(raw[0] * 4000);
                s.y          = 32'(raw[1] * 4000);
                s.z          = 32'(raw[2] * 4000);
                s.temp       = 32'd0;
                s.temp_valid = 1'b0;
            end
            imu_sfd_pkg::TYPE_ANGLE: begin
                s.kind       = imu_sfd_pkg::KIND_ANGLE;
                s.x          = 32'(raw[0] * 360);
                s.y          = 32'(raw[1] * 360);
                s.z          = 32'(raw[2] * 360);
                s.temp       = 32'd0;
                s.temp_valid = 1'b0;
            end
            imu_sfd_pkg::TYPE_MAG: begin
                s.kind       = imu_sfd_pkg::KIND_MAG;
                s.x          = 32'(raw[0] * 65536);
                s.y          = 32'(raw[1] * 65536);
                s.z          = 32'(raw[2] * 65536);
                s.temp       = 32'(raw[3] * 65536);
                s.temp_valid = 1'b1;
            end
            default: begin
                return;
            end
        endcase
        expected_samples.push_back(s);
    endfunction

    task automatic send_rx_byte(logic [7:0] rx);
        @(negedge i_clk);
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= rx;
        do @(posedge i_clk); while (!o_s_axis_tready);
        decode_rx_byte(rx);
        bytes_sent++;
    endtask

    task automatic send_frame(logic [7:0] type_byte, logic [15:0] w0, logic [15:0] w1,
                              logic [15:0] w2, logic [15:0] w3, bit corrupt);
        logic [7:0] frame [FRAME_LEN];
        logic [7:0] sum;
        frame[0] = imu_sfd_pkg::HDR_BYTE;
        frame[1] = type_byte;
        {frame[3], frame[2]} = w0;
        {frame[5], frame[4]} = w1;
        {frame[7], frame[6]} = w2;
        {frame[9], frame[8]} = w3;
        sum = 8'd0;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + frame[i];
        frame[FRAME_LEN - 1] = corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        for (int i = 0; i < FRAME_LEN; i++) send_rx_byte(frame[i]);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_unknown_type();
        logic [7:0] t;
        do t = 8'($urandom);
        while (t >= imu_sfd_pkg::TYPE_ACC && t <= imu_sfd_pkg::TYPE_MAG);
        return t;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_imu_sample want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_samples.size() == 0) begin
                error_count++;
                $display("%0t: unexpected item, expected none, actual %h %h", $time,
                         o_m_axis_tuser, o_m_axis_tdata);
            end else begin
                want = expected_samples.pop_front();
                check_field("frame_kind", 32'(want.kind), 32'(o_m_axis_tuser[1:0]));
                check_field("value_x", want.x, o_m_axis_tdata[31:0]);
                check_field("value_y", want.y, o_m_axis_tdata[63:32]);
                check_field("value_z", want.z, o_m_axis_tdata[95:64]);
                check_field("temperature", want.temp, o_m_axis_tdata[127:96]);
                check_field("temperature_valid", 32'(want.temp_valid), 32'(o_m_axis_tuser[2]));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (idle_enable && $urandom_range(0, 2) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    task automatic test_noise_bytes();
        send_rx_byte(8'h00);
        send_rx_byte(8'hff);
        send_rx_byte(8'haa);
        send_rx_byte(imu_sfd_pkg::TYPE_MAG);
    endtask

    task automatic test_frame_kinds();
        send_frame(imu_sfd_pkg::TYPE_ACC, 16'h8000, 16'h7fff, 16'hffff, 16'h8000, 1'b0);
        send_frame(imu_sfd_pkg::TYPE_ACC, 16'h0001, 16'hfffe, 16'h0005, 16'hff9d, 1'b0);
        send_frame(imu_sfd_pkg::TYPE_RATE, 16'h7fff, 16'h8000, 16'h0001, 16'h0000, 1'b0);
        send_frame(imu_sfd_pkg::TYPE_ANGLE, 16'h8000, 16'h7fff, 16'h0000, 16'hffff, 1'b0);
        send_frame(imu_sfd_pkg::TYPE_MAG, 16'h7fff, 16'h8000, 16'hffff, 16'h7fff, 1'b0);
    endtask

    task automatic test_unknown_type();
        send_frame(8'h50, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 1'b0);
        send_frame(imu_sfd_pkg::TYPE_RATE, 16'h0010, 16'hfff0, 16'h0100, 16'h0000, 1'b0);
    endtask

    // A bad sum makes the window slide; the following good frame must still decode.
    task automatic test_bad_checksum();
        send_frame(imu_sfd_pkg::TYPE_ACC, 16'h0100, 16'h0200, 16'h0300, 16'h0a00, 1'b1);
        send_frame(imu_sfd_pkg::TYPE_ANGLE, 16'h0055, 16'h5555, 16'h0001, 16'h0002, 1'b0);
    endtask

    task automatic test_drain_pause();
        send_frame(imu_sfd_pkg::TYPE_MAG, pick_word(), pick_word(), pick_word(), pick_word(),
                   1'b0);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_random_traffic(int byte_target);
        int pick;
        int len;
        while (bytes_sent < byte_target) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_frame(8'(imu_sfd_pkg::TYPE_ACC + $urandom_range(0, 3)), pick_word(),
                           pick_word(), pick_word(), pick_word(), 1'b0);
            end else if (pick < 72) begin
                send_frame(pick_unknown_type(), pick_word(), pick_word(), pick_word(),
                           pick_word(), 1'b0);
            end else if (pick < 82) begin
                send_frame(8'(imu_sfd_pkg::TYPE_ACC + $urandom_range(0, 3)), pick_word(),
                           pick_word(), pick_word(), pick_word(), 1'b1);
            end else if (pick < 91) begin
                len = $urandom_range(1, 5);
                repeat (len) send_rx_byte(8'($urandom));
            end else begin
                len = $urandom_range(1, 9);
                send_rx_byte(imu_sfd_pkg::HDR_BYTE);
                repeat (len) send_rx_byte(8'($urandom));
            end
        end
    endtask

    task automatic test_steady_tail();
        idle_enable = 1'b0;
        test_random_traffic(TOTAL_BYTES);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        idle_enable     = 1'b1;
        held_bytes      = 0;
        error_count     = 0;
        bytes_sent      = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_noise_bytes();
        test_frame_kinds();
        test_unknown_type();
        test_bad_checksum();
        test_drain_pause();
        test_random_traffic(RANDOM_BYTES / 2);
        test_drain_pause();
        test_random_traffic(RANDOM_BYTES);
        test_steady_tail();

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: imu_serial_frame_decoder_top.f
design/imu_sfd_pkg.sv
design/imu_serial_frame_decoder_top.sv
dv/imu_serial_frame_decoder_top_tb.sv
